// ===== rtl/tkoc_pkg.sv =====
// Shared types and constants for the touch key offset calibrator.
`timescale 1ns / 1ps
package tkoc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RAW_MIN       = 3'd0;
   localparam logic [2:0] CSR_RAW_MAX       = 3'd1;
   localparam logic [2:0] CSR_PASS_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_OFFSET_RESET  = 3'd3;
   localparam logic [2:0] CSR_REPORT_ENABLE = 3'd4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] RAW_MIN_RESET       = 16'd250;
   localparam logic [15:0] RAW_MAX_RESET       = 16'd1750;
   localparam logic [3:0]  PASS_LIMIT_RESET    = 4'd2;
   localparam logic [7:0]  OFFSET_RESET_RESET  = 8'h12;
   localparam logic        REPORT_ENABLE_RESET = 1'b1;

   // Offset field and status bits.
   localparam logic [4:0] OFFSET_FIELD_MAX = 5'h1F;
   localparam int         STATUS_CHANGED_BIT = 3;
   localparam int         STATUS_DOWN_BIT    = 1;

   // Position of the averaging window where the decision is made.
   localparam logic [2:0] WINDOW_LAST = 3'd4;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_IRQ   = 2'd0,
      CMD_WAKE  = 2'd1,
      CMD_SLEEP = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_WAKE,
      OP_SLEEP,
      OP_IGNORE
   } op_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef struct packed {
      logic [15:0] raw_min;
      logic [15:0] raw_max;
      logic [3:0]  pass_limit;
      logic [7:0]  offset_reset;
      logic        report_enable;
   } cfg_type;

   // One classified word as it travels from front to back.
   typedef struct packed {
      op_type      op;
      logic [15:0] raw;
      logic        key_flag;
      logic        key_down;
   } entry_type;

endpackage

// ===== rtl/tkoc_front.sv =====
// Front end: accepts request words and classifies them into queue entries.
`timescale 1ns / 1ps
module tkoc_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [15:0]          req_raw_sample,
   input  logic [7:0]           req_status_byte,
   input  tkoc_pkg::cfg_type    cfg,
   output logic                 push_valid,
   input  logic                 push_ready,
   output tkoc_pkg::entry_type  push_entry
);
   import tkoc_pkg::*;

   cmd_type cmd;

   assign cmd        = cmd_type'(req_command);
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_entry.raw = req_raw_sample;
      // A key report is only possible when reporting is on and the key changed.
      push_entry.key_flag = cfg.report_enable & req_status_byte[STATUS_CHANGED_BIT];
      push_entry.key_down = req_status_byte[STATUS_DOWN_BIT];
      case (cmd)
         CMD_IRQ:   push_entry.op = OP_SAMPLE;
         CMD_WAKE:  push_entry.op = OP_WAKE;
         CMD_SLEEP: push_entry.op = OP_SLEEP;
         default:   push_entry.op = OP_IGNORE;
      endcase
   end

endmodule

// ===== rtl/tkoc_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
`timescale 1ns / 1ps
module tkoc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tkoc_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tkoc_pkg::entry_type  pop_entry
);
   import tkoc_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   function automatic logic [PTR_WIDTH-1:0] ptr_step(input logic [PTR_WIDTH-1:0] p);
      ptr_step = (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_WIDTH'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/tkoc_back.sv =====
// Back end: mode and calibration state, offset stepping and the result register.
`timescale 1ns / 1ps
module tkoc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tkoc_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tkoc_pkg::entry_type  pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_key_event,
   output logic                 rsp_key_pressed,
   output logic                 rsp_offset_write,
   output logic [7:0]           rsp_offset_value,
   output logic                 rsp_calibrating,
   output logic                 rsp_calibration_done
);
   import tkoc_pkg::*;

   logic        normal_mode_ff, normal_mode_in;
   logic        cal_active_ff, cal_active_in;
   logic [2:0]  window_ff, window_in;
   logic [3:0]  pass_ff, pass_in;
   logic [17:0] sum_ff, sum_in;
   dir_type     prev_dir_ff, prev_dir_in;
   logic [7:0]  offset_ff, offset_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        key_event_ff, key_event_in;
   logic        key_pressed_ff, key_pressed_in;
   logic        offset_write_ff, offset_write_in;
   logic        done_ff, done_in;

   logic        take;
   logic [17:0] sum_next;
   logic [15:0] average;
   logic [3:0]  limit;
   dir_type     dir;
   logic [7:0]  offset_step;
   logic        finish;

   assign take      = pop_valid & (~rsp_valid_ff | rsp_ready);
   assign pop_ready = ~rsp_valid_ff | rsp_ready;

   // Window arithmetic and the step decision for the last sample of a window.
   always_comb begin
      sum_next = (window_ff == '0) ? '0 : sum_ff + {2'b00, pop_entry.raw};
      average  = sum_next[17:2];
      limit    = (cfg.pass_limit == '0) ? 4'd1 : cfg.pass_limit;
      dir         = DIR_NONE;
      offset_step = offset_ff;
      if (average < cfg.raw_min) begin
         if (offset_ff[4:0] != '0) begin
            dir         = DIR_DOWN;
            offset_step = offset_ff - 8'd1;
         end
      end else if (average > cfg.raw_max) begin
         if (offset_ff[4:0] != OFFSET_FIELD_MAX) begin
            dir         = DIR_UP;
            offset_step = offset_ff + 8'd1;
         end
      end
      // A reversal after the first pass means the offset has settled.
      if (pass_ff != '0 && dir != prev_dir_ff) begin
         dir = DIR_NONE;
      end
      finish = ({1'b0, pass_ff} + 5'd1) >= {1'b0, limit};
   end

   always_comb begin
      normal_mode_in  = normal_mode_ff;
      cal_active_in   = cal_active_ff;
      window_in       = window_ff;
      pass_in         = pass_ff;
      sum_in          = sum_ff;
      prev_dir_in     = prev_dir_ff;
      offset_in       = offset_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      key_event_in    = key_event_ff;
      key_pressed_in  = key_pressed_ff;
      offset_write_in = offset_write_ff;
      done_in         = done_ff;
      if (take) begin
         rsp_valid_in    = 1'b1;
         key_event_in    = 1'b0;
         key_pressed_in  = 1'b0;
         offset_write_in = 1'b0;
         done_in         = 1'b0;
         case (pop_entry.op)
            OP_WAKE: begin
               if (!normal_mode_ff) begin
                  normal_mode_in = 1'b1;
                  offset_in      = cfg.offset_reset;
                  cal_active_in  = 1'b1;
                  pass_in        = '0;
                  window_in      = '0;
               end
            end
            OP_SLEEP: begin
               normal_mode_in = 1'b0;
            end
            OP_SAMPLE: begin
               if (normal_mode_ff && cal_active_ff) begin
                  sum_in    = sum_next;
                  window_in = (window_ff < WINDOW_LAST) ? window_ff + 3'd1 : '0;
                  if (window_ff == WINDOW_LAST) begin
                     if (dir == DIR_NONE) begin
                        cal_active_in = 1'b0;
                        pass_in       = '0;
                        done_in       = 1'b1;
                     end else begin
                        offset_in       = offset_step;
                        offset_write_in = 1'b1;
                        if (finish) begin
                           cal_active_in = 1'b0;
                           pass_in       = '0;
                           done_in       = 1'b1;
                        end else begin
                           prev_dir_in = dir;
                           pass_in     = pass_ff + 4'd1;
                        end
                     end
                  end
               end else if (pop_entry.key_flag) begin
                  key_event_in   = 1'b1;
                  key_pressed_in = pop_entry.key_down;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_mode_ff <= 1'b1;
         cal_active_ff  <= 1'b1;
         window_ff      <= '0;
         pass_ff        <= '0;
         sum_ff         <= '0;
         prev_dir_ff    <= DIR_NONE;
         offset_ff      <= OFFSET_RESET_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         normal_mode_ff <= normal_mode_in;
         cal_active_ff  <= cal_active_in;
         window_ff      <= window_in;
         pass_ff        <= pass_in;
         sum_ff         <= sum_in;
         prev_dir_ff    <= prev_dir_in;
         offset_ff      <= offset_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_event_ff    <= key_event_in;
      key_pressed_ff  <= key_pressed_in;
      offset_write_ff <= offset_write_in;
      done_ff         <= done_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_key_event        = key_event_ff;
   assign rsp_key_pressed      = key_pressed_ff;
   assign rsp_offset_write     = offset_write_ff;
   assign rsp_offset_value     = offset_ff;
   assign rsp_calibrating      = cal_active_ff;
   assign rsp_calibration_done = done_ff;

endmodule

// ===== rtl/touch_key_offset_calibrator_unit.sv =====
// Top level of the touch key offset calibrator: configuration registers and the datapath.
`timescale 1ns / 1ps
// Usage
// The request channel (req_) carries one event word per handshake: a sensor
// interrupt with its raw sample and status byte, a wake command or a sleep
// command. The response channel (rsp_) returns exactly one word per request,
// in order: key event and pressed flags, whether the offset was rewritten,
// the current offset value, and the calibration status.
// A front end classifies each request and drops it into a two-entry queue;
// the back end updates the mode and calibration state and loads the result
// register. Each accepted request is written into the queue, and its response
// is then loaded into the result register. While rsp_ready stays high, the
// block sustains one word per cycle in both directions.
// When the receiver stalls, the result register holds its word and the queue
// keeps absorbing requests until both of its entries are in use, after which
// req_ready drops; no word is lost or repeated.
// Reset puts the block in normal mode with calibration active, the offset at
// the reset value of its load register, and all configuration registers at
// their defaults. The configuration port writes one register per cycle with
// csr_write_enable and should be used only while no word is in flight.
module touch_key_offset_calibrator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [15:0]                           req_raw_sample,
   input  logic [7:0]                            req_status_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_key_event,
   output logic                                  rsp_key_pressed,
   output logic                                  rsp_offset_write,
   output logic [7:0]                            rsp_offset_value,
   output logic                                  rsp_calibrating,
   output logic                                  rsp_calibration_done,
   input  logic                                  csr_write_enable,
   input  logic [tkoc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tkoc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import tkoc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // Register writes; an index outside the register list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RAW_MIN:       cfg_in.raw_min       = csr_write_data;
            CSR_RAW_MAX:       cfg_in.raw_max       = csr_write_data;
            CSR_PASS_LIMIT:    cfg_in.pass_limit    = csr_write_data[3:0];
            CSR_OFFSET_RESET:  cfg_in.offset_reset  = csr_write_data[7:0];
            CSR_REPORT_ENABLE: cfg_in.report_enable = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_min       <= RAW_MIN_RESET;
         cfg_ff.raw_max       <= RAW_MAX_RESET;
         cfg_ff.pass_limit    <= PASS_LIMIT_RESET;
         cfg_ff.offset_reset  <= OFFSET_RESET_RESET;
         cfg_ff.report_enable <= REPORT_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tkoc_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_raw_sample  (req_raw_sample),
      .req_status_byte (req_status_byte),
      .cfg             (cfg_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   tkoc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tkoc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_entry            (pop_entry),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_key_event        (rsp_key_event),
      .rsp_key_pressed      (rsp_key_pressed),
      .rsp_offset_write     (rsp_offset_write),
      .rsp_offset_value     (rsp_offset_value),
      .rsp_calibrating      (rsp_calibrating),
      .rsp_calibration_done (rsp_calibration_done)
   );

endmodule

// ===== rtl/tkoc_checker.sv =====
// Port-level checks for the touch key offset calibrator, bound to the top level.
`timescale 1ns / 1ps
module tkoc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_key_event,
   input logic       rsp_key_pressed,
   input logic       rsp_offset_write,
   input logic [7:0] rsp_offset_value,
   input logic       rsp_calibrating,
   input logic       rsp_calibration_done
);

   // A pressed flag only comes with a reported key event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_pressed |-> rsp_key_event)
      else $error("key pressed without key event");

   // The word that ends calibration already shows calibration off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibration_done |-> !rsp_calibrating)
      else $error("calibration done while still calibrating");

   // Key reporting and offset writes never share a word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_write |-> !rsp_key_event)
      else $error("offset write together with key event");

   // An offset write that does not end calibration leaves it running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_write && !rsp_calibration_done |-> rsp_calibrating)
      else $error("offset write outside calibration");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset_value)
         && $stable(rsp_key_event) && $stable(rsp_calibration_done))
      else $error("response word changed while stalled");

endmodule

bind touch_key_offset_calibrator_unit tkoc_checker u_tkoc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_key_event        (rsp_key_event),
   .rsp_key_pressed      (rsp_key_pressed),
   .rsp_offset_write     (rsp_offset_write),
   .rsp_offset_value     (rsp_offset_value),
   .rsp_calibrating      (rsp_calibrating),
   .rsp_calibration_done (rsp_calibration_done)
);
